>>> hdl/b58_pkg.sv
package b58_pkg;

    localparam int OUT_BYTES = 25;
    localparam int ACC_W     = 8 * OUT_BYTES;
    // acc * 58 + digit stays below 2^(ACC_W + 6)
    localparam int PROD_W    = ACC_W + 6;
    localparam int IDX_W     = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADCHAR  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic       valid;
        logic [5:0] digit;
    } t_digit;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [ACC_W-1:0] acc;
    } t_load;

    // alphabet lookup: the digits 1 to 9, then letters without I, O and l
    function automatic t_digit char_to_digit(input logic [7:0] c);
        t_digit d;
        d.valid = 1'b1;
        d.digit = '0;
        if (c inside {[8'h31:8'h39]}) begin
            d.digit = 6'(c - 8'h31);
        end else if (c inside {[8'h41:8'h48]}) begin
            d.digit = 6'(c - 8'h41 + 8'd9);
        end else if (c inside {[8'h4A:8'h4E]}) begin
            d.digit = 6'(c - 8'h4A + 8'd17);
        end else if (c inside {[8'h50:8'h5A]}) begin
            d.digit = 6'(c - 8'h50 + 8'd22);
        end else if (c inside {[8'h61:8'h6B]}) begin
            d.digit = 6'(c - 8'h61 + 8'd33);
        end else if (c inside {[8'h6D:8'h7A]}) begin
            d.digit = 6'(c - 8'h6D + 8'd44);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

>>> hdl/b58_in_if.sv
interface b58_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

>>> hdl/b58_out_if.sv
interface b58_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_byte;

    modport source (output valid, output out_byte, output status, output last_byte,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_byte,
                    output ready);
endinterface

>>> hdl/b58_accum.sv
module b58_accum (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    b58_in_if.sink                   i_in,
    input  logic                     i_load_ok,
    output b58_pkg::t_load           o_load
);

    logic                        r_valid;
    logic [7:0]                  r_char;
    logic                        r_eos;
    logic [b58_pkg::ACC_W-1:0]   r_acc;
    b58_pkg::t_status            r_err;

    logic                        advance;
    b58_pkg::t_digit             dig;
    logic [b58_pkg::PROD_W-1:0]  acc_ext;
    logic [b58_pkg::PROD_W-1:0]  prod;
    logic [b58_pkg::ACC_W-1:0]   n_acc;
    b58_pkg::t_status            n_err;

    assign advance    = r_valid && (!r_eos || i_load_ok);
    assign i_in.ready = !r_valid || advance;

    assign dig     = b58_pkg::char_to_digit(r_char);
    assign acc_ext = b58_pkg::PROD_W'(r_acc);
    // times 58 as 32 + 16 + 8 + 2
    assign prod    = (acc_ext << 5) + (acc_ext << 4) + (acc_ext << 3) + (acc_ext << 1)
                   + b58_pkg::PROD_W'(dig.digit);

    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (r_err == b58_pkg::ST_OK) begin
            if (!dig.valid) begin
                n_err = b58_pkg::ST_BADCHAR;
            end else if (|prod[b58_pkg::PROD_W-1:b58_pkg::ACC_W]) begin
                n_err = b58_pkg::ST_OVERFLOW;
            end else begin
                n_acc = prod[b58_pkg::ACC_W-1:0];
            end
        end
    end

    always_comb begin
        o_load.valid  = advance && r_eos;
        o_load.status = n_err;
        o_load.acc    = (n_err == b58_pkg::ST_OK) ? n_acc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_err   <= b58_pkg::ST_OK;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            if (advance) begin
                if (r_eos) begin
                    r_acc <= '0;
                    r_err <= b58_pkg::ST_OK;
                end else begin
                    r_acc <= n_acc;
                    r_err <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_code;
            r_eos  <= i_in.end_of_string;
        end
    end

    a_clear_after_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load.valid |=> (r_acc == '0) && (r_err == b58_pkg::ST_OK))
        else $error("accumulator not cleared after final character");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != b58_pkg::ST_OK) && !(advance && r_eos) |=> r_err == $past(r_err))
        else $error("error code changed within a string");

    a_error_holds_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != b58_pkg::ST_OK) && !(advance && r_eos) |=> $stable(r_acc))
        else $error("accumulator moved after an error");

endmodule

>>> hdl/b58_serialiser.sv
module b58_serialiser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  b58_pkg::t_load           i_load,
    output logic                     o_load_ok,
    b58_out_if.source                o_out
);

    logic                        r_busy;
    logic [b58_pkg::ACC_W-1:0]   r_shift;
    b58_pkg::t_status            r_status;
    logic [b58_pkg::IDX_W-1:0]   r_idx;

    logic                        take;
    logic                        last;

    assign take      = o_out.valid && o_out.ready;
    assign last      = (r_idx == b58_pkg::IDX_W'(b58_pkg::OUT_BYTES - 1));
    assign o_load_ok = !r_busy || (take && last);

    assign o_out.valid     = r_busy;
    assign o_out.out_byte  = r_shift[b58_pkg::ACC_W-1 -: 8];
    assign o_out.status    = 2'(r_status);
    assign o_out.last_byte = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_load.valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (take) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // most significant byte leaves first
    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_shift  <= i_load.acc;
            r_status <= i_load.status;
        end else if (take) begin
            r_shift <= r_shift << 8;
        end
    end

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.valid |-> o_load_ok)
        else $error("new value loaded over undelivered bytes");

    a_error_zero_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_status != b58_pkg::ST_OK) |-> o_out.out_byte == 8'd0)
        else $error("nonzero byte with error status");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && last |=> !r_busy || (r_idx == '0))
        else $error("byte count ran past the final byte");

endmodule

>>> hdl/base58_string_decoder_core.sv
// Base58 decoder: one character is taken per cycle while no final character waits, and each is
// registered at the input and then folded into a 200-bit accumulator (times 58 plus digit).
// The final character of a string hands the value and its status to an output shift
// register, which sends 25 bytes, most significant first, one per cycle while the sink is
// ready; characters of the next string keep flowing in meanwhile, and only a further final
// character waits until the last of the previous 25 bytes is taken. A bad character or an
// overflow makes every byte of that string read zero with a nonzero status.
module base58_string_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b58_in_if.sink      i_in,
    b58_out_if.source   o_out
);

    b58_pkg::t_load     load;
    logic               load_ok;

    b58_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_load_ok (load_ok),
        .o_load    (load)
    );

    b58_serialiser u_serialiser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .o_load_ok (load_ok),
        .o_out     (o_out)
    );

endmodule
